### rtl/sasd_pkg.sv
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared widths, register indexes and sequencer states for the sensor angle
// scale and deadband unit.
// ----------------------------------------------------------------------------
package sasd_pkg;

   localparam int MV_W    = 12;  // millivolt fields
   localparam int ANGLE_W = 17;  // signed angle fields, 0.01 deg
   localparam int DBAND_W = 16;  // deadband register
   localparam int SPAN_W  = ANGLE_W + 1;            // angle span, signed
   localparam int MC_W    = ANGLE_W;                // angle span magnitude
   localparam int WORK_W  = MC_W + MV_W + 1;        // product / dividend
   localparam int SUM_W   = WORK_W + 2;             // signed sum before clamp
   localparam int CNT_W   = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = ANGLE_W;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MV_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORK_W - 1);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLT_LOW    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLT_HIGH   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_FIRST = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_SECND = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEADBAND    = 3'd4;

   // reset values
   localparam logic [MV_W-1:0]    RST_VOLT_LOW    = 12'd150;
   localparam logic [MV_W-1:0]    RST_VOLT_HIGH   = 12'd3000;
   localparam logic [ANGLE_W-1:0] RST_ANGLE_FIRST = 17'h1EE6C;  // -4500
   localparam logic [ANGLE_W-1:0] RST_ANGLE_SECND = 17'h01194;  // 4500
   localparam logic [DBAND_W-1:0] RST_DEADBAND    = 16'd50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_DECIDE
   } state_type;

endpackage

### rtl/sensor_angle_scale_deadband_unit.sv
// ----------------------------------------------------------------------------
// sensor_angle_scale_deadband_unit
// Maps a millivolt sample linearly onto a configured angle span, clamps it, and
// flags a report, sink permitting, at a deadband or more from the last report.
// ----------------------------------------------------------------------------
// sequence: an accepted sample runs 12 multiply steps, 30 divide steps, then
//   clamp and decide; with a zero voltage span it goes straight to clamp
// the unit takes no new sample until the last one leaves decide, as the
//   bit-serial shift-add multiplier and restoring divider share one
//   work register; a stalled response holds the unit in decide
// reset: synchronous; registers return to defaults, no reference angle held
// ----------------------------------------------------------------------------
module sensor_angle_scale_deadband_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sasd_pkg::MV_W-1:0]             req_sample_mv,
   input  logic                                  req_sink_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sasd_pkg::ANGLE_W-1:0]   rsp_angle_value,
   output logic                                  rsp_report_now,
   input  logic                                  csr_we,
   input  logic [sasd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [sasd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int MV_W    = sasd_pkg::MV_W;
   localparam int ANGLE_W = sasd_pkg::ANGLE_W;
   localparam int DBAND_W = sasd_pkg::DBAND_W;
   localparam int SPAN_W  = sasd_pkg::SPAN_W;
   localparam int MC_W    = sasd_pkg::MC_W;
   localparam int WORK_W  = sasd_pkg::WORK_W;
   localparam int SUM_W   = sasd_pkg::SUM_W;
   localparam int CNT_W   = sasd_pkg::CNT_W;

   // configuration registers
   logic [MV_W-1:0]           volt_low_ff, volt_high_ff;
   logic signed [ANGLE_W-1:0] angle_first_ff, angle_secnd_ff;
   logic [DBAND_W-1:0]        deadband_ff;

   sasd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [WORK_W-1:0] work_ff, work_in;
   logic [MC_W-1:0]   mcand_ff, mcand_in;
   logic [MV_W-1:0]   divisor_ff, divisor_in;
   logic [MV_W-1:0]   rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic              zero_span_ff, zero_span_in;
   logic              sink_rdy_ff, sink_rdy_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;

   logic signed [ANGLE_W-1:0] ref_angle_ff, ref_angle_in;
   logic                      ref_valid_ff, ref_valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic                      rsp_report_ff, rsp_report_in;

   logic accept, out_free, report;

   // operand setup at accept
   logic signed [MV_W:0]   dv, vspan;
   logic signed [SPAN_W-1:0] aspan;
   logic [MV_W-1:0]        dv_mag, vspan_mag;
   logic [MC_W-1:0]        aspan_mag;

   // serial step logic
   logic [WORK_W-WORK_W+MC_W+1:0] psum;
   logic [MV_W:0]                 trial_in, trial;

   // clamp and deadband
   logic signed [SUM_W-1:0]   q_signed, a_sum, lo_x, hi_x;
   logic signed [ANGLE_W-1:0] lo_end, hi_end;
   logic signed [ANGLE_W:0]   diff;
   logic [ANGLE_W-1:0]        diff_mag;
   logic                      changed;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle_value = rsp_angle_ff;
   assign rsp_report_now  = rsp_report_ff;

   assign dv        = $signed({1'b0, req_sample_mv}) - $signed({1'b0, volt_low_ff});
   assign vspan     = $signed({1'b0, volt_high_ff}) - $signed({1'b0, volt_low_ff});
   assign aspan     = SPAN_W'(angle_secnd_ff) - SPAN_W'(angle_first_ff);
   assign dv_mag    = dv[MV_W] ? MV_W'(-dv) : dv[MV_W-1:0];
   assign vspan_mag = vspan[MV_W] ? MV_W'(-vspan) : vspan[MV_W-1:0];
   assign aspan_mag = aspan[SPAN_W-1] ? MC_W'(-aspan) : aspan[MC_W-1:0];

   // shift-add step: high part gains the multiplicand when the low bit is set
   assign psum = {1'b0, work_ff[WORK_W-1:MV_W]} +
                 (work_ff[0] ? {2'b00, mcand_ff} : '0);

   // restoring divide step
   assign trial_in = {rem_ff, work_ff[WORK_W-1]};
   assign trial    = trial_in - {1'b0, divisor_ff};

   assign lo_end   = (angle_first_ff < angle_secnd_ff) ? angle_first_ff : angle_secnd_ff;
   assign hi_end   = (angle_first_ff < angle_secnd_ff) ? angle_secnd_ff : angle_first_ff;
   assign lo_x     = SUM_W'(lo_end);
   assign hi_x     = SUM_W'(hi_end);
   assign q_signed = neg_ff ? -$signed({2'b00, work_ff}) : $signed({2'b00, work_ff});
   assign a_sum    = SUM_W'(angle_first_ff) + q_signed;

   assign diff     = (ANGLE_W+1)'(angle_ff) - (ANGLE_W+1)'(ref_angle_ff);
   assign diff_mag = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
   assign changed  = !ref_valid_ff || (diff_mag >= {1'b0, deadband_ff});
   assign report   = changed && sink_rdy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sasd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (volt_low_ff == volt_high_ff) ? sasd_pkg::ST_CLAMP
                                                        : sasd_pkg::ST_MUL;
            end
         end
         sasd_pkg::ST_MUL: begin
            if (cnt_ff == sasd_pkg::MUL_LAST) state_in = sasd_pkg::ST_DIV;
         end
         sasd_pkg::ST_DIV: begin
            if (cnt_ff == sasd_pkg::DIV_LAST) state_in = sasd_pkg::ST_CLAMP;
         end
         sasd_pkg::ST_CLAMP:  state_in = sasd_pkg::ST_DECIDE;
         sasd_pkg::ST_DECIDE: begin
            if (out_free) state_in = sasd_pkg::ST_IDLE;
         end
         default: state_in = sasd_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = (state_ff == sasd_pkg::ST_IDLE);
      cnt_in        = cnt_ff;
      work_in       = work_ff;
      mcand_in      = mcand_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      zero_span_in  = zero_span_ff;
      sink_rdy_in   = sink_rdy_ff;
      angle_in      = angle_ff;
      ref_angle_in  = ref_angle_ff;
      ref_valid_in  = ref_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_angle_in  = rsp_angle_ff;
      rsp_report_in = rsp_report_ff;
      case (state_ff)
         sasd_pkg::ST_IDLE: begin
            if (accept) begin
               work_in      = {{(WORK_W-MV_W){1'b0}}, dv_mag};
               mcand_in     = aspan_mag;
               divisor_in   = vspan_mag;
               neg_in       = dv[MV_W] ^ aspan[SPAN_W-1] ^ vspan[MV_W];
               zero_span_in = (volt_low_ff == volt_high_ff);
               sink_rdy_in  = req_sink_ready;
               cnt_in       = '0;
            end
         end
         sasd_pkg::ST_MUL: begin
            work_in = {psum, work_ff[MV_W-1:1]};
            rem_in  = '0;
            cnt_in  = (cnt_ff == sasd_pkg::MUL_LAST) ? '0 : cnt_ff + 1'b1;
         end
         sasd_pkg::ST_DIV: begin
            if (!trial[MV_W]) begin
               rem_in  = trial[MV_W-1:0];
               work_in = {work_ff[WORK_W-2:0], 1'b1};
            end else begin
               rem_in  = trial_in[MV_W-1:0];
               work_in = {work_ff[WORK_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         sasd_pkg::ST_CLAMP: begin
            if (zero_span_ff || a_sum < lo_x) begin
               angle_in = lo_end;
            end else if (a_sum > hi_x) begin
               angle_in = hi_end;
            end else begin
               angle_in = a_sum[ANGLE_W-1:0];
            end
         end
         sasd_pkg::ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_angle_in  = angle_ff;
               rsp_report_in = report;
               if (report) begin
                  ref_angle_in = angle_ff;
                  ref_valid_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sasd_pkg::ST_IDLE;
         cnt_ff         <= '0;
         ref_angle_ff   <= '0;
         ref_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         volt_low_ff    <= sasd_pkg::RST_VOLT_LOW;
         volt_high_ff   <= sasd_pkg::RST_VOLT_HIGH;
         angle_first_ff <= sasd_pkg::RST_ANGLE_FIRST;
         angle_secnd_ff <= sasd_pkg::RST_ANGLE_SECND;
         deadband_ff    <= sasd_pkg::RST_DEADBAND;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ref_angle_ff <= ref_angle_in;
         ref_valid_ff <= ref_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               sasd_pkg::CSR_VOLT_LOW:    volt_low_ff    <= csr_wdata[MV_W-1:0];
               sasd_pkg::CSR_VOLT_HIGH:   volt_high_ff   <= csr_wdata[MV_W-1:0];
               sasd_pkg::CSR_ANGLE_FIRST: angle_first_ff <= csr_wdata;
               sasd_pkg::CSR_ANGLE_SECND: angle_secnd_ff <= csr_wdata;
               sasd_pkg::CSR_DEADBAND:    deadband_ff    <= csr_wdata[DBAND_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      mcand_ff      <= mcand_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      zero_span_ff  <= zero_span_in;
      sink_rdy_ff   <= sink_rdy_in;
      angle_ff      <= angle_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_report_ff <= rsp_report_in;
   end

   // once a report is made the reference stays valid
   a_ref_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      ref_valid_ff |=> ref_valid_ff)
      else $error("reference valid dropped");

   // a reported word becomes the reference
   a_report_sets_ref: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sasd_pkg::ST_DECIDE && out_free && report) |=>
         (rsp_valid_ff && rsp_report_ff && ref_angle_ff == rsp_angle_ff))
      else $error("report did not update reference");

   // an accepted sample always starts a computation
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sasd_pkg::ST_MUL || state_ff == sasd_pkg::ST_CLAMP))
      else $error("accepted sample not started");

   // a reporting word implies a held reference
   a_report_has_ref: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_report_ff) |-> ref_valid_ff)
      else $error("report without reference");

endmodule

### tb/sasd_angle_checker.sv
// ----------------------------------------------------------------------------
// sasd_angle_checker
// Watches the register port and both channels of the angle unit, keeps its
// own copy of the registers and of the last reported angle, predicts every
// response word and compares it, field by field, with what comes out.
// ----------------------------------------------------------------------------
module sasd_angle_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [sasd_pkg::MV_W-1:0]             req_sample_mv,
   input  logic                                  req_sink_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [sasd_pkg::ANGLE_W-1:0]   rsp_angle_value,
   input  logic                                  rsp_report_now,
   input  logic                                  csr_we,
   input  logic [sasd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [sasd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                    fail_count,
   output int                                    words_pending,
   output int                                    reports_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MV_W    = sasd_pkg::MV_W;
   localparam int ANGLE_W = sasd_pkg::ANGLE_W;
   localparam int DBAND_W = sasd_pkg::DBAND_W;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      report_now;
   } angle_word_type;

   angle_word_type expected_words[$];

   logic [MV_W-1:0]           volt_low;
   logic [MV_W-1:0]           volt_high;
   logic signed [ANGLE_W-1:0] angle_first;
   logic signed [ANGLE_W-1:0] angle_second;
   logic [DBAND_W-1:0]        deadband;
   logic signed [ANGLE_W-1:0] last_reported;
   logic                      have_reported;

   // linear map from the voltage span onto the angle span, clamped to the ends
   function automatic logic signed [ANGLE_W-1:0] scaled_angle(
      input logic [MV_W-1:0] mv);
      longint vspan;
      longint aspan;
      longint lo;
      longint hi;
      longint a;
      vspan = longint'(volt_high) - longint'(volt_low);
      aspan = longint'(angle_second) - longint'(angle_first);
      lo = (angle_first < angle_second) ? longint'(angle_first) : longint'(angle_second);
      hi = (angle_first < angle_second) ? longint'(angle_second) : longint'(angle_first);
      if (vspan == 0)
         return ANGLE_W'(lo);
      a = longint'(angle_first) + ((longint'(mv) - longint'(volt_low)) * aspan) / vspan;
      if (a < lo)
         a = lo;
      if (a > hi)
         a = hi;
      return ANGLE_W'(a);
   endfunction

   always @(posedge clock) begin
      angle_word_type want;
      longint         delta;
      if (reset) begin
         volt_low      = sasd_pkg::RST_VOLT_LOW;
         volt_high     = sasd_pkg::RST_VOLT_HIGH;
         angle_first   = sasd_pkg::RST_ANGLE_FIRST;
         angle_second  = sasd_pkg::RST_ANGLE_SECND;
         deadband      = sasd_pkg::RST_DEADBAND;
         last_reported = '0;
         have_reported = 1'b0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               sasd_pkg::CSR_VOLT_LOW:    volt_low     = csr_wdata[MV_W-1:0];
               sasd_pkg::CSR_VOLT_HIGH:   volt_high    = csr_wdata[MV_W-1:0];
               sasd_pkg::CSR_ANGLE_FIRST: angle_first  = csr_wdata[ANGLE_W-1:0];
               sasd_pkg::CSR_ANGLE_SECND: angle_second = csr_wdata[ANGLE_W-1:0];
               sasd_pkg::CSR_DEADBAND:    deadband     = csr_wdata[DBAND_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want.angle = scaled_angle(req_sample_mv);
            delta = longint'(want.angle) - longint'(last_reported);
            if (delta < 0)
               delta = -delta;
            want.report_now = req_sink_ready && (!have_reported || delta >= longint'(deadband));
            if (want.report_now) begin
               last_reported = want.angle;
               have_reported = 1'b1;
            end
            expected_words.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: word with nothing expected: angle %0d report %0b",
                        $time, rsp_angle_value, rsp_report_now);
            end else begin
               want = expected_words.pop_front();
               if (want.report_now)
                  reports_seen++;
               if (rsp_angle_value !== want.angle) begin
                  fail_count++;
                  $display("%0t: angle_value expected %0d actual %0d",
                           $time, want.angle, rsp_angle_value);
               end
               if (rsp_report_now !== want.report_now) begin
                  fail_count++;
                  $display("%0t: report_now expected %0b actual %0b (angle %0d)",
                           $time, want.report_now, rsp_report_now, want.angle);
               end
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

### tb/tb_sensor_angle_scale_deadband_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_angle_scale_deadband_unit
// Drives millivolt samples into the angle unit under a series of register
// settings (reset values, reversed and zero spans, extreme angle ends and
// deadbands, then random ones), with random idle gaps on the request side
// and random backpressure on the response side. The checker beside the
// block predicts and compares every word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sensor_angle_scale_deadband_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MV_W       = sasd_pkg::MV_W;
   localparam int ANGLE_W    = sasd_pkg::ANGLE_W;
   localparam int CSR_ADDR_W = sasd_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = sasd_pkg::CSR_DATA_W;

   localparam int RANDOM_SETTINGS = 8;
   localparam int SAMPLES_PER_SETTING = 60;
   localparam int SETTLE_CYCLES = 60;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [MV_W-1:0]           req_sample_mv;
   logic                      req_sink_ready;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [ANGLE_W-1:0] rsp_angle_value;
   logic                      rsp_report_now;
   logic                      csr_we;
   logic [CSR_ADDR_W-1:0]     csr_addr;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   int fail_count;
   int words_pending;
   int reports_seen;
   int samples_sent = 0;
   int settings_used = 0;
   bit sender_steady = 1'b0;

   always #2 clock = ~clock;

   sensor_angle_scale_deadband_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_mv   (req_sample_mv),
      .req_sink_ready  (req_sink_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_angle_value (rsp_angle_value),
      .rsp_report_now  (rsp_report_now),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   sasd_angle_checker angle_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_mv   (req_sample_mv),
      .req_sink_ready  (req_sink_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_angle_value (rsp_angle_value),
      .rsp_report_now  (rsp_report_now),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .words_pending   (words_pending),
      .reports_seen    (reports_seen)
   );

   // response backpressure: long fully-ready stretches mixed with short and long stalls
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            run = $urandom_range(200, 600);
            stall = 0;
         end else begin
            run = $urandom_range(1, 40);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         end
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_sample(input int mv, input bit sink_ok);
      int gap;
      req_sample_mv  <= MV_W'(mv);
      req_sink_ready <= sink_ok;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
      if (sender_steady || $urandom_range(0, 9) < 6)
         gap = 0;
      else if ($urandom_range(0, 3) != 0)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic put_reg(input logic [CSR_ADDR_W-1:0] addr,
                          input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // unused upper bits of the narrow registers get random junk
   task automatic load_setting(input int vlow, input int vhigh, input int aone, input int atwo,
                               input int dband);
      put_reg(sasd_pkg::CSR_VOLT_LOW, {5'($urandom), 12'(vlow)});
      put_reg(sasd_pkg::CSR_VOLT_HIGH, {5'($urandom), 12'(vhigh)});
      put_reg(sasd_pkg::CSR_ANGLE_FIRST, 17'(aone));
      put_reg(sasd_pkg::CSR_ANGLE_SECND, 17'(atwo));
      put_reg(sasd_pkg::CSR_DEADBAND, {1'($urandom), 16'(dband)});
      if ($urandom_range(0, 2) == 0)
         put_reg(CSR_ADDR_W'($urandom_range(int'(sasd_pkg::CSR_DEADBAND) + 1, 7)),
                 17'($urandom));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // block stays idle until every predicted word is back
   task automatic end_phase();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      sender_steady = ($urandom_range(0, 3) == 0);
   endtask

   function automatic int pick_mv();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic int pick_angle();
      case ($urandom_range(0, 9))
         0:       return -65536;
         1:       return 65535;
         2:       return -36000;
         3:       return 36000;
         default: return int'($urandom_range(0, 72000)) - 36000;
      endcase
   endfunction

   initial begin
      int vlow;
      int vhigh;
      int aone;
      int atwo;
      int dband;
      int mv;
      int prev_mv;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_mv  = '0;
      req_sink_ready = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = sasd_pkg::CSR_VOLT_LOW;
      csr_wdata      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: first report held off by the sink, then deadband steps
      send_sample(1000, 1'b0);
      send_sample(1000, 1'b1);
      send_sample(1010, 1'b1);
      send_sample(1016, 1'b1);
      send_sample(0, 1'b1);
      send_sample(4095, 1'b0);
      send_sample(4095, 1'b1);
      send_sample(150, 1'b1);
      send_sample(3000, 1'b1);
      end_phase();

      // reversed voltage span, widest angle ends, zero deadband
      load_setting(4095, 0, 65535, -65536, 0);
      send_sample(0, 1'b1);
      send_sample(4095, 1'b1);
      send_sample(2048, 1'b1);
      send_sample(2048, 1'b1);
      send_sample(1, 1'b0);
      end_phase();

      // zero voltage span gives the lower end, largest deadband
      load_setting(2000, 2000, 36000, -36000, 65535);
      send_sample(2000, 1'b1);
      send_sample(4095, 1'b1);
      end_phase();

      load_setting(0, 4095, -36000, 36000, 36000);
      send_sample(0, 1'b1);
      send_sample(4095, 1'b1);
      send_sample(2048, 1'b1);
      end_phase();

      prev_mv = 2048;
      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         vlow  = pick_mv();
         vhigh = ($urandom_range(0, 7) == 0) ? vlow : pick_mv();
         aone  = pick_angle();
         atwo  = pick_angle();
         case ($urandom_range(0, 9))
            0:       dband = 0;
            1:       dband = 65535;
            2:       dband = $urandom_range(0, 36000);
            default: dband = $urandom_range(1, 400);
         endcase
         load_setting(vlow, vhigh, aone, atwo, dband);
         for (int i = 0; i < SAMPLES_PER_SETTING; i++) begin
            // small steps around the last sample probe the deadband edge
            case ($urandom_range(0, 9))
               0, 1, 2, 3: mv = $urandom_range(0, 4095);
               4:          mv = ($urandom_range(0, 1) != 0) ? 4095 : 0;
               5:          mv = vlow + int'($urandom_range(0, 8)) - 4;
               default:    mv = prev_mv + int'($urandom_range(0, 60)) - 30;
            endcase
            if (mv < 0)
               mv = 0;
            if (mv > 4095)
               mv = 4095;
            prev_mv = mv;
            send_sample(mv, $urandom_range(0, 4) != 0);
         end
         end_phase();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d samples under %0d register settings plus reset values",
               samples_sent, settings_used);
      $display("%0d words predicted as reports, %0d checker failures",
               reports_seen, fail_count);
      if (fail_count == 0 && words_pending == 0)
         $display("[sensor_angle_scale_deadband_unit] OK");
      else
         $display("[sensor_angle_scale_deadband_unit] ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d words outstanding", words_pending);
      $display("[sensor_angle_scale_deadband_unit] ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/sasd_pkg.sv
rtl/sensor_angle_scale_deadband_unit.sv
tb/sasd_angle_checker.sv
tb/tb_sensor_angle_scale_deadband_unit.sv
